// ----- src/bsr_pkg.sv -----
// Shared types, constants and the frame suffix table for the barcode serial reader.
package bsr_pkg;

    localparam int CODE_CHARS_DEF  = 13;
    localparam int FRAME_BYTES_DEF = 20;
    localparam int SUFFIX_LEN      = 7;
    localparam int DATA_BITS       = 8;

    localparam logic [7:0] MARK_BIT = 8'h04;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_MARK  = 3'd1,
        PH_DATA  = 3'd2,
        PH_GAP   = 3'd3,
        PH_IDLE  = 3'd4
    } phase_t;

    // One load request as seen by the code store.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [3:0] idx;
        logic [7:0] value;
    } load_req_t;

    // Fixed bytes that follow the scanned code in every frame.
    function automatic logic [7:0] suffix_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h53;
            3'd1:    b = 8'h55;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h53;
            3'd4:    b = 8'h4F;
            3'd5:    b = 8'h46;
            3'd6:    b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- src/barcode_serial_reader_top.sv -----
// Top level of the barcode serial reader: stream ports, code store, sequencer, output stage.
//
// Every input request gives exactly one result. A load request (command set) writes one
// code character into the staging bank; with tlast set it commits the staged string and
// arms the frame. A read request (command clear) returns bus_bits_in, with bit 2 ORed with
// the sequence when the second port is read while armed: one start mark per frame, then
// per frame byte one mark, eight inverted data bits LSB first and one gap, until
// FRAME_BYTES bytes are sent. Commits swap the two memory banks, so a commit needs no copy.
// The result of an accepted request is registered in the output stage before m_tdata.
// Throughput is one request per cycle while m_tready stays high; a frame byte is read from
// the code memory on the mark read and used on the next second-port read.
// The output register is backed by a skid stage: while the receiver holds m_tready low,
// one more request is still taken, then s_tready drops until the result is drained.
// Reset leaves the reader disarmed with an empty code; the memory needs no clearing pass.
module barcode_serial_reader_top
    import bsr_pkg::*;
#(
    parameter int CODE_CHARS  = CODE_CHARS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_bits_in[7:0], char_index[11:8], char_value[19:12], zero
    input  logic [1:0]  s_tuser,   // command[0], port_select[1]
    input  logic        s_tlast,   // load_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // read_data[7:0]
);

    localparam int IW = (CODE_CHARS > 1) ? $clog2(CODE_CHARS) : 1;

    logic          accept;
    logic          command;
    load_req_t     load;
    logic          commit;
    logic          fetch_valid;
    logic [IW-1:0] fetch_idx;
    logic [7:0]    fetch_data;
    logic [7:0]    read_data;

    assign accept  = s_tvalid && s_tready;
    assign command = s_tuser[0];

    assign load.valid = accept && (command == CMD_LOAD);
    assign load.last  = s_tlast;
    assign load.idx   = s_tdata[11:8];
    assign load.value = s_tdata[19:12];
    assign commit     = load.valid && s_tlast;

    bsr_code_store #(
        .CODE_CHARS (CODE_CHARS),
        .IW         (IW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .fetch_valid (fetch_valid),
        .fetch_idx   (fetch_idx),
        .fetch_data  (fetch_data)
    );

    bsr_sequencer #(
        .CODE_CHARS  (CODE_CHARS),
        .FRAME_BYTES (FRAME_BYTES),
        .IW          (IW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (accept),
        .command     (command),
        .port_select (s_tuser[1]),
        .bus_bits_in (s_tdata[7:0]),
        .commit      (commit),
        .fetch_valid (fetch_valid),
        .fetch_idx   (fetch_idx),
        .fetch_data  (fetch_data),
        .read_data   (read_data)
    );

    bsr_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (read_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- src/bsr_code_store.sv -----
// Two-bank code memory: one bank stages characters while the other holds the committed code.
module bsr_code_store
    import bsr_pkg::*;
#(
    parameter int CODE_CHARS = CODE_CHARS_DEF,
    parameter int IW         = (CODE_CHARS > 1) ? $clog2(CODE_CHARS) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  load_req_t       load,
    input  logic            fetch_valid,
    input  logic [IW-1:0]   fetch_idx,
    output logic [7:0]      fetch_data
);

    localparam int LW    = $clog2(CODE_CHARS + 1);
    localparam int DEPTH = 2 ** (IW + 1);

    logic [7:0]            mem [0:DEPTH-1];
    logic                  stg_bank_reg;
    logic [CODE_CHARS-1:0] nz_reg;
    logic [CODE_CHARS-1:0] nz_next;
    logic [LW-1:0]         code_len_reg;
    logic [LW-1:0]         term;
    logic [7:0]            rdata_reg;
    logic                  hit_reg;
    logic [31:0]           idx32;
    logic                  in_range;
    logic                  wr_en;
    logic [IW:0]           waddr;
    logic [CODE_CHARS-1:0] nz_eff;

    assign idx32    = 32'(load.idx);
    assign in_range = idx32 < 32'(CODE_CHARS);
    assign wr_en    = load.valid && in_range;
    assign waddr    = {stg_bank_reg, idx32[IW-1:0]};

    // A staged position counts as part of the string only if its latest write was nonzero;
    // positions not written since the last commit read as a terminator.
    always_comb
    begin
        nz_eff = nz_reg;
        if (wr_en)
        begin
            nz_eff[idx32[IW-1:0]] = (load.value != 8'h00);
        end
        term = LW'(CODE_CHARS);
        for (int i = CODE_CHARS - 1; i >= 0; i--)
        begin
            if (!nz_eff[i])
            begin
                term = LW'(i);
            end
        end
        nz_next = (load.valid && load.last) ? '0 : nz_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_bank_reg <= 1'b0;
            nz_reg       <= '0;
            code_len_reg <= '0;
        end
        else
        begin
            nz_reg <= nz_next;
            if (load.valid && load.last)
            begin
                code_len_reg <= term;
                stg_bank_reg <= ~stg_bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= load.value;
        end
        if (fetch_valid)
        begin
            rdata_reg <= mem[{~stg_bank_reg, fetch_idx}];
            hit_reg   <= 32'(fetch_idx) < 32'(code_len_reg);
        end
    end

    assign fetch_data = hit_reg ? rdata_reg : 8'h00;

endmodule

// ----- src/bsr_sequencer.sv -----
// Five-state read sequencer that drives the mark and data bit onto the port read value.
module bsr_sequencer
    import bsr_pkg::*;
#(
    parameter int CODE_CHARS  = CODE_CHARS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int IW          = (CODE_CHARS > 1) ? $clog2(CODE_CHARS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic          command,
    input  logic          port_select,
    input  logic [7:0]    bus_bits_in,
    input  logic          commit,
    output logic          fetch_valid,
    output logic [IW-1:0] fetch_idx,
    input  logic [7:0]    fetch_data,
    output logic [7:0]    read_data
);

    localparam int BPW = $clog2(FRAME_BYTES + 1);

    phase_t         phase_reg;
    phase_t         phase_next;
    logic [BPW-1:0] ptr_reg;
    logic [BPW-1:0] ptr_next;
    logic [BPW-1:0] ptr_plus;
    logic [3:0]     bit_count_reg;
    logic [3:0]     bit_count_next;
    logic [3:0]     bit_count_plus;
    logic [7:0]     shift_reg;
    logic [7:0]     shift_next;
    logic           pending_reg;
    logic           pending_next;
    logic           use_mem_reg;
    logic [7:0]     alt_reg;
    logic [7:0]     cur_byte;
    logic           step;
    logic [7:0]     mark;
    logic [31:0]    ptr32;
    logic [31:0]    sfx32;
    logic           ptr_in_code;
    logic [7:0]     alt_byte;

    assign ptr32       = 32'(ptr_reg);
    assign sfx32       = ptr32 - 32'(CODE_CHARS);
    assign ptr_in_code = ptr32 < 32'(CODE_CHARS);
    assign alt_byte    = (sfx32 < 32'(SUFFIX_LEN)) ? suffix_byte(sfx32[2:0]) : 8'h00;
    assign fetch_idx   = ptr32[IW-1:0];
    assign ptr_plus    = ptr_reg + BPW'(1);
    assign bit_count_plus = bit_count_reg + 4'd1;

    // The first data read after the mark read takes the fetched or suffix byte directly.
    assign cur_byte = pending_reg ? (use_mem_reg ? fetch_data : alt_reg) : shift_reg;

    assign step = item_valid && (command == CMD_READ) && port_select && (phase_reg != PH_IDLE);

    always_comb
    begin
        phase_next     = phase_reg;
        ptr_next       = ptr_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        pending_next   = pending_reg;
        fetch_valid    = 1'b0;
        mark           = 8'h00;
        if (commit)
        begin
            phase_next = PH_START;
            ptr_next   = '0;
        end
        else if (step)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    phase_next = PH_MARK;
                    ptr_next   = '0;
                    mark       = MARK_BIT;
                end
                PH_MARK:
                begin
                    phase_next     = PH_DATA;
                    fetch_valid    = ptr_in_code;
                    pending_next   = 1'b1;
                    bit_count_next = 4'd0;
                    mark           = MARK_BIT;
                end
                PH_DATA:
                begin
                    mark           = cur_byte[0] ? 8'h00 : MARK_BIT;
                    shift_next     = cur_byte >> 1;
                    pending_next   = 1'b0;
                    bit_count_next = bit_count_plus;
                    if (32'(bit_count_plus) >= 32'(DATA_BITS))
                    begin
                        phase_next = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    ptr_next = ptr_plus;
                    if (32'(ptr_plus) >= 32'(FRAME_BYTES))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_MARK;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        read_data = (command == CMD_LOAD) ? 8'h00 : (bus_bits_in | mark);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ptr_reg       <= '0;
            bit_count_reg <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ptr_reg       <= ptr_next;
            bit_count_reg <= bit_count_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (step && (phase_reg == PH_MARK))
        begin
            use_mem_reg <= ptr_in_code;
            alt_reg     <= alt_byte;
        end
    end

endmodule

// ----- src/bsr_out_skid.sv -----
// Output register with a skid stage that holds one more result while the receiver stalls.
module bsr_out_skid
    import bsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic [7:0] skid_data_reg;
    logic [7:0] skid_data_next;
    logic       accept;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = in_data;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- verif/barcode_serial_reader_top_test.sv -----
// Self-checking testbench for the barcode serial reader top level.
`timescale 1ns / 1ps

module barcode_serial_reader_top_test;
    import bsr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic       command;
        logic       port_select;
        logic [7:0] bus_bits;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic       load_last;
    } scan_req_t;

    // Fixed frame tail that follows the scanned code.
    localparam logic [7:0] FRAME_TAIL [SUFFIX_LEN] = '{
        8'h53, 8'h55, 8'h4E, 8'h53, 8'h4F, 8'h46, 8'h54
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // bus_bits_in[7:0], char_index[11:8], char_value[19:12], zero
    logic [1:0]  s_tuser;   // command[0], port_select[1]
    logic        s_tlast;   // load_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // read_data[7:0]

    // Reader state as predicted from the accepted requests.
    phase_t     reader_phase;
    logic [4:0] frame_ptr;
    logic [7:0] shift_bits;
    logic [3:0] bits_sent;
    logic       reader_armed;
    logic [7:0] code_mem  [CODE_CHARS_DEF];
    logic [7:0] stage_mem [CODE_CHARS_DEF];

    logic [7:0] expected_read_data [$];
    int         mismatch_count;
    int         requests_sent;
    int         cycle_count;
    logic       burst_mode;

    barcode_serial_reader_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [7:0] frame_byte_at(input int p);
        if (p < CODE_CHARS_DEF)
            return code_mem[p];
        if (p - CODE_CHARS_DEF < SUFFIX_LEN)
            return FRAME_TAIL[p - CODE_CHARS_DEF];
        return 8'h00;
    endfunction

    // Advances the predicted reader by one request and gives its read data.
    task automatic predict_read_data(input scan_req_t r, output logic [7:0] data);
        logic ended;
        data = r.bus_bits;
        if (r.command == CMD_LOAD)
        begin
            data = 8'h00;
            if (r.char_index < CODE_CHARS_DEF)
                stage_mem[r.char_index] = r.char_value;
            if (r.load_last)
            begin
                // String copy: everything from the first zero byte on reads as zero.
                ended = 1'b0;
                for (int i = 0; i < CODE_CHARS_DEF; i++)
                begin
                    if (stage_mem[i] == 8'h00)
                        ended = 1'b1;
                    code_mem[i]  = ended ? 8'h00 : stage_mem[i];
                    stage_mem[i] = 8'h00;
                end
                reader_phase = PH_START;
                frame_ptr    = '0;
                reader_armed = 1'b1;
            end
        end
        else if (r.port_select && reader_armed)
        begin
            case (reader_phase)
                PH_START:
                begin
                    reader_phase = PH_MARK;
                    frame_ptr    = '0;
                    data         = data | MARK_BIT;
                end
                PH_MARK:
                begin
                    reader_phase = PH_DATA;
                    shift_bits   = frame_byte_at(int'(frame_ptr));
                    bits_sent    = '0;
                    data         = data | MARK_BIT;
                end
                PH_DATA:
                begin
                    data[2]    = data[2] | ~shift_bits[0];
                    shift_bits = shift_bits >> 1;
                    bits_sent  = bits_sent + 4'd1;
                    if (bits_sent > 4'd7)
                        reader_phase = PH_GAP;
                end
                PH_GAP:
                begin
                    frame_ptr = frame_ptr + 5'd1;
                    if (int'(frame_ptr) >= FRAME_BYTES_DEF)
                    begin
                        reader_phase = PH_IDLE;
                        reader_armed = 1'b0;
                    end
                    else
                    begin
                        reader_phase = PH_MARK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Valid stays high straight into the next request when no gap is drawn.
    task automatic send_request(input scan_req_t r);
        int         gap;
        logic [7:0] want;
        gap = draw_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, r.char_value, r.char_index, r.bus_bits};
        s_tuser  <= {r.port_select, r.command};
        s_tlast  <= r.load_last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_read_data(r, want);
        expected_read_data.push_back(want);
        requests_sent++;
    endtask

    task automatic send_load(input logic [3:0] idx, input logic [7:0] value,
                             input logic last);
        scan_req_t r;
        r.command     = CMD_LOAD;
        r.port_select = 1'($urandom_range(0, 1));
        r.bus_bits    = 8'($urandom_range(0, 255));
        r.char_index  = idx;
        r.char_value  = value;
        r.load_last   = last;
        send_request(r);
    endtask

    task automatic send_read(input logic sel, input logic [7:0] bus);
        scan_req_t r;
        r.command     = CMD_READ;
        r.port_select = sel;
        r.bus_bits    = bus;
        r.char_index  = 4'($urandom_range(0, 15));
        r.char_value  = 8'($urandom_range(0, 255));
        r.load_last   = 1'($urandom_range(0, 1));
        send_request(r);
    endtask

    // Reads while disarmed pass the bus bits through on either port, then one load without tlast.
    task automatic test_idle_reads();
        send_read(1'b0, 8'h00);
        send_read(1'b1, 8'hFF);
        send_read(1'b1, 8'h00);
        send_read(1'b0, 8'hFF);
        send_load(4'd7, 8'h00, 1'b0);
    endtask

    // Extreme characters, out-of-range indexes, terminators and a restart mid-frame.
    task automatic test_load_rules();
        send_load(4'd0, 8'hFF, 1'b0);
        send_load(4'd12, 8'h80, 1'b0);
        send_load(4'd15, 8'hAA, 1'b0);
        send_load(4'd13, 8'h55, 1'b1);
        send_read(1'b1, 8'h00);
        send_read(1'b1, 8'hFB);
        send_read(1'b0, 8'h5A);
        send_read(1'b1, 8'h00);
        send_read(1'b1, 8'hFF);
        send_load(4'd5, 8'h31, 1'b0);
        send_load(4'd0, 8'h00, 1'b1);
        send_read(1'b1, 8'h00);
        send_read(1'b1, 8'h00);
        send_read(1'b1, 8'h00);
        send_read(1'b1, 8'hFB);
        send_read(1'b1, 8'h00);
    endtask

    // Loads one code with random content, then steps the frame by port reads.
    task automatic run_scan_session(input int port_reads);
        int         style;
        int         cut;
        int         done;
        logic       extra;
        logic [7:0] value;
        style = $urandom_range(0, 3);
        cut   = $urandom_range(0, CODE_CHARS_DEF);
        extra = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < CODE_CHARS_DEF; i++)
        begin
            case (style)
                0:       value = 8'h30 + 8'($urandom_range(0, 9));
                1:       value = 8'($urandom_range(1, 255));
                2:       value = (i == cut) ? 8'h00 : 8'($urandom_range(1, 255));
                default: value = 8'($urandom_range(0, 255));
            endcase
            // A skipped position stays zero and ends the string there.
            if (i == CODE_CHARS_DEF - 1 || $urandom_range(0, 15) != 0)
                send_load(4'(i), value, (i == CODE_CHARS_DEF - 1) && !extra);
        end
        if (extra)
            send_load(4'($urandom_range(CODE_CHARS_DEF, 15)), 8'($urandom_range(0, 255)),
                      1'b1);
        done = 0;
        while (done < port_reads)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_read(1'b0, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_read(1'b1, 8'($urandom_range(0, 255)));
                done++;
            end
        end
    endtask

    // Complete frames, including reads past the end of each.
    task automatic test_full_frames();
        burst_mode = 1'b1;
        run_scan_session(1 + FRAME_BYTES_DEF * 11 + 3);
        burst_mode = 1'b0;
        run_scan_session(1 + FRAME_BYTES_DEF * 11 + 3);
    endtask

    // Mostly well-formed sessions, some cut short by the next commit, plus noise.
    task automatic test_random_traffic();
        scan_req_t r;
        int        kind;
        while (requests_sent < RANDOM_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                run_scan_session(1 + FRAME_BYTES_DEF * 11 + int'($urandom_range(0, 4)));
            end
            else if (kind < 8)
            begin
                run_scan_session($urandom_range(1, FRAME_BYTES_DEF * 11));
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                begin
                    r.command     = 1'($urandom_range(0, 1));
                    r.port_select = 1'($urandom_range(0, 1));
                    r.bus_bits    = 8'($urandom_range(0, 255));
                    r.char_index  = 4'($urandom_range(0, 15));
                    r.char_value  = 8'($urandom_range(0, 255));
                    r.load_last   = ($urandom_range(0, 7) == 0);
                    send_request(r);
                end
            end
        end
    endtask

    // Receiver: holds m_tready low for a drawn gap before each result, then checks it.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (expected_read_data.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result read_data=%02h", m_tdata));
            end
            else
            begin
                if (m_tdata !== expected_read_data[0])
                    report_mismatch($sformatf("read_data expected %02h got %02h",
                                              expected_read_data[0], m_tdata));
                void'(expected_read_data.pop_front());
            end
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        s_tlast        <= 1'b0;
        m_tready       <= 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        requests_sent  = 0;
        burst_mode     = 1'b0;
        reader_phase   = PH_IDLE;
        frame_ptr      = '0;
        shift_bits     = '0;
        bits_sent      = '0;
        reader_armed   = 1'b0;
        for (int i = 0; i < CODE_CHARS_DEF; i++)
        begin
            code_mem[i]  = 8'h00;
            stage_mem[i] = 8'h00;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_reads();
        test_load_rules();
        test_full_frames();
        test_random_traffic();
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (expected_read_data.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (expected_read_data.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_read_data.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
